### rtl/core/vlpw_pkg.sv
// ----------------------------------------------------------------------------
// vlpw_pkg
// Shared types and constants for the voxel line pick walker.
// ----------------------------------------------------------------------------
package vlpw_pkg;

  localparam int CW = 16;       // voxel coordinate width
  localparam int EW = CW + 3;   // error term width

  typedef enum logic {
    OP_START = 1'b0,
    OP_REPLY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_MISS  = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // walk context: positions, driving axis goal, signs, doubled spans, errors
  typedef struct packed {
    logic [2:0][CW-1:0] pos;
    logic [CW-1:0]      end_drive;
    logic [2:0]         sign;
    axis_t              axis;
    logic [EW-1:0]      sd2;
    logic [1:0][EW-1:0] sm2;
    logic [1:0][EW-1:0] err;
  } walk_t;

endpackage

### rtl/core/vlpw_setup.sv
// ----------------------------------------------------------------------------
// vlpw_setup
// Line setup: spans, step signs, driving axis and initial error terms.
// ----------------------------------------------------------------------------
module vlpw_setup (
  input  logic [2:0][vlpw_pkg::CW-1:0] start_pos,
  input  logic [2:0][vlpw_pkg::CW-1:0] goal_pos,
  output vlpw_pkg::walk_t              walk
);

  logic [2:0][vlpw_pkg::CW:0] diff;
  logic [2:0][vlpw_pkg::CW:0] span;
  logic [2:0]                 sign;
  vlpw_pkg::axis_t            axis;
  logic [vlpw_pkg::CW:0]      span_d;
  logic [vlpw_pkg::CW:0]      span_m0;
  logic [vlpw_pkg::CW:0]      span_m1;
  logic [vlpw_pkg::CW-1:0]    end_drive;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {start_pos[i][vlpw_pkg::CW-1], start_pos[i]}
              - {goal_pos[i][vlpw_pkg::CW-1], goal_pos[i]};
      sign[i] = !diff[i][vlpw_pkg::CW] && (diff[i] != '0);
      span[i] = diff[i][vlpw_pkg::CW] ? (~diff[i] + 1'b1) : diff[i];
    end
  end

  always_comb begin
    if (span[0] >= span[1] && span[0] >= span[2]) begin
      axis = vlpw_pkg::AXIS_X;
    end else if (span[1] >= span[2]) begin
      axis = vlpw_pkg::AXIS_Y;
    end else begin
      axis = vlpw_pkg::AXIS_Z;
    end
  end

  always_comb begin
    unique case (axis)
      vlpw_pkg::AXIS_X: begin
        span_d = span[0]; span_m0 = span[1]; span_m1 = span[2]; end_drive = goal_pos[0];
      end
      vlpw_pkg::AXIS_Y: begin
        span_d = span[1]; span_m0 = span[0]; span_m1 = span[2]; end_drive = goal_pos[1];
      end
      vlpw_pkg::AXIS_Z: begin
        span_d = span[2]; span_m0 = span[0]; span_m1 = span[1]; end_drive = goal_pos[2];
      end
      default: begin
        span_d = '0; span_m0 = '0; span_m1 = '0; end_drive = '0;
      end
    endcase
  end

  always_comb begin
    walk.pos       = start_pos;
    walk.end_drive = end_drive;
    walk.sign      = sign;
    walk.axis      = axis;
    walk.sd2       = {1'b0, span_d, 1'b0};
    walk.sm2[0]    = {1'b0, span_m0, 1'b0};
    walk.sm2[1]    = {1'b0, span_m1, 1'b0};
    walk.err[0]    = {1'b0, span_m0, 1'b0} - {2'b00, span_d};
    walk.err[1]    = {1'b0, span_m1, 1'b0} - {2'b00, span_d};
  end

endmodule

### rtl/core/vlpw_step.sv
// ----------------------------------------------------------------------------
// vlpw_step
// One Bresenham step: end check, voxel advance and error update.
// ----------------------------------------------------------------------------
module vlpw_step (
  input  vlpw_pkg::walk_t walk,
  output vlpw_pkg::walk_t walk_nxt,
  output logic            at_end
);

  logic       e0_go;
  logic       e1_go;
  logic [2:0] mv;

  assign e0_go = !walk.err[0][vlpw_pkg::EW-1];
  assign e1_go = !walk.err[1][vlpw_pkg::EW-1];

  always_comb begin
    unique case (walk.axis)
      vlpw_pkg::AXIS_X: begin
        at_end = (walk.pos[0] == walk.end_drive);
        mv     = {e1_go, e0_go, 1'b1};
      end
      vlpw_pkg::AXIS_Y: begin
        at_end = (walk.pos[1] == walk.end_drive);
        mv     = {e1_go, 1'b1, e0_go};
      end
      vlpw_pkg::AXIS_Z: begin
        at_end = (walk.pos[2] == walk.end_drive);
        mv     = {1'b1, e1_go, e0_go};
      end
      default: begin
        at_end = 1'b1;
        mv     = '0;
      end
    endcase
  end

  always_comb begin
    walk_nxt = walk;
    for (int i = 0; i < 3; i++) begin
      if (mv[i]) begin
        walk_nxt.pos[i] = walk.sign[i] ? (walk.pos[i] - 1'b1) : (walk.pos[i] + 1'b1);
      end
    end
    walk_nxt.err[0] = walk.err[0] - (e0_go ? walk.sd2 : '0) + walk.sm2[0];
    walk_nxt.err[1] = walk.err[1] - (e1_go ? walk.sd2 : '0) + walk.sm2[1];
  end

endmodule

### rtl/core/voxel_line_pick_walker.sv
// ----------------------------------------------------------------------------
// voxel_line_pick_walker
// A result word passes the setup register and then the result register; out_ready can stall it.
// Throughput: one word per cycle while out_ready holds; a setup register feeds the step stage.
// Reset (rst_n low, synchronous) empties both stages and leaves the walker idle.
// 3D Bresenham voxel walk that stops at the first visible voxel.
// ----------------------------------------------------------------------------
module voxel_line_pick_walker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic signed [vlpw_pkg::CW-1:0] in_start_x,
  input  logic signed [vlpw_pkg::CW-1:0] in_start_y,
  input  logic signed [vlpw_pkg::CW-1:0] in_start_z,
  input  logic signed [vlpw_pkg::CW-1:0] in_goal_x,
  input  logic signed [vlpw_pkg::CW-1:0] in_goal_y,
  input  logic signed [vlpw_pkg::CW-1:0] in_goal_z,
  input  logic                           in_visible,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic signed [vlpw_pkg::CW-1:0] out_vox_x,
  output logic signed [vlpw_pkg::CW-1:0] out_vox_y,
  output logic signed [vlpw_pkg::CW-1:0] out_vox_z
);

  // setup stage
  logic                            s1_valid_r;
  vlpw_pkg::op_t                   s1_op_r;
  logic                            s1_vis_r;
  vlpw_pkg::walk_t                 s1_walk_r;
  vlpw_pkg::walk_t                 setup_walk;
  logic [2:0][vlpw_pkg::CW-1:0]    start_pos;
  logic [2:0][vlpw_pkg::CW-1:0]    goal_pos;

  // step stage and walk state
  logic                            walking_r;
  logic                            walking_nxt;
  vlpw_pkg::walk_t                 state_r;
  vlpw_pkg::walk_t                 state_nxt;
  vlpw_pkg::walk_t                 src;
  vlpw_pkg::walk_t                 step_walk;
  logic                            at_end;
  logic                            s2_take;

  // result register
  logic                            out_valid_r;
  vlpw_pkg::kind_t                 out_kind_r;
  vlpw_pkg::kind_t                 kind_nxt;
  logic [2:0][vlpw_pkg::CW-1:0]    vox_r;
  logic [2:0][vlpw_pkg::CW-1:0]    vox_nxt;

  assign start_pos = {in_start_z, in_start_y, in_start_x};
  assign goal_pos  = {in_goal_z, in_goal_y, in_goal_x};

  vlpw_setup u_setup (
    .start_pos (start_pos),
    .goal_pos  (goal_pos),
    .walk      (setup_walk)
  );

  assign s2_take  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= vlpw_pkg::op_t'(in_op);
      s1_vis_r  <= in_visible;
      s1_walk_r <= setup_walk;
    end
  end

  assign src = (s1_op_r == vlpw_pkg::OP_START) ? s1_walk_r : state_r;

  vlpw_step u_step (
    .walk     (src),
    .walk_nxt (step_walk),
    .at_end   (at_end)
  );

  always_comb begin
    walking_nxt = walking_r;
    state_nxt   = state_r;
    kind_nxt    = vlpw_pkg::KIND_IDLE;
    vox_nxt     = '0;
    if (s1_op_r == vlpw_pkg::OP_START || (walking_r && !s1_vis_r)) begin
      if (at_end) begin
        walking_nxt = 1'b0;
        state_nxt   = src;
        kind_nxt    = vlpw_pkg::KIND_MISS;
      end else begin
        walking_nxt = 1'b1;
        state_nxt   = step_walk;
        kind_nxt    = vlpw_pkg::KIND_PROBE;
        vox_nxt     = step_walk.pos;
      end
    end else if (walking_r) begin
      walking_nxt = 1'b0;
      kind_nxt    = vlpw_pkg::KIND_HIT;
      vox_nxt     = state_r.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_take) begin
        walking_r <= walking_nxt;
      end
      if (s2_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      state_r    <= state_nxt;
      out_kind_r <= kind_nxt;
      vox_r      <= vox_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_vox_x = vox_r[0];
  assign out_vox_y = vox_r[1];
  assign out_vox_z = vox_r[2];

  // an empty setup stage always takes a word
  a_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("setup stage empty but input not ready");

  // walking follows the kind of the last result word
  a_walk_kind: assert property (@(posedge clk) disable iff (!rst_n)
    s2_take |=> (walking_r == (out_kind_r == vlpw_pkg::KIND_PROBE)))
    else $error("walking flag disagrees with last result kind");

  // miss and idle words carry zero coordinates
  a_zero_vox: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == vlpw_pkg::KIND_MISS || out_kind_r == vlpw_pkg::KIND_IDLE)
    |-> (vox_r == '0))
    else $error("nonzero coordinates on miss or idle word");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for voxel_line_pick_walker. A table of directed words
// (idle replies, equal endpoints, axis ties, coordinate extremes, restarts
// mid-walk, stray bits) runs first. Random line walks follow, most of them
// short and well formed, with restarts and idle replies mixed in. Every
// result word is checked against the want of a typed row, else against
// the bench's cycle-free Bresenham walker. Both sides stall at random, the
// receiver blocks for a long stretch, and the sender drains the block once.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    vlpw_pkg::kind_t                kind;
    logic signed [vlpw_pkg::CW-1:0] x;
    logic signed [vlpw_pkg::CW-1:0] y;
    logic signed [vlpw_pkg::CW-1:0] z;
  } vox_word_t;

  typedef struct packed {
    vlpw_pkg::op_t                  op;
    logic signed [vlpw_pkg::CW-1:0] sx;
    logic signed [vlpw_pkg::CW-1:0] sy;
    logic signed [vlpw_pkg::CW-1:0] sz;
    logic signed [vlpw_pkg::CW-1:0] gx;
    logic signed [vlpw_pkg::CW-1:0] gy;
    logic signed [vlpw_pkg::CW-1:0] gz;
    logic                           vis;
    logic                           typed;
    vox_word_t                      want;
  } dir_row_t;

  localparam int N_RANDOM = 550;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_op;
  logic signed [vlpw_pkg::CW-1:0] in_start_x;
  logic signed [vlpw_pkg::CW-1:0] in_start_y;
  logic signed [vlpw_pkg::CW-1:0] in_start_z;
  logic signed [vlpw_pkg::CW-1:0] in_goal_x;
  logic signed [vlpw_pkg::CW-1:0] in_goal_y;
  logic signed [vlpw_pkg::CW-1:0] in_goal_z;
  logic                           in_visible;
  logic                           out_valid;
  logic                           out_ready;
  logic [1:0]                     out_kind;
  logic signed [vlpw_pkg::CW-1:0] out_vox_x;
  logic signed [vlpw_pkg::CW-1:0] out_vox_y;
  logic signed [vlpw_pkg::CW-1:0] out_vox_z;

  logic      row_typed;
  vox_word_t row_want;

  vox_word_t pending_vox [$];
  int        n_bad = 0;

  // walker state
  logic                           walk_on = 1'b0;
  logic signed [vlpw_pkg::CW-1:0] wpos [3] = '{0, 0, 0};
  logic signed [vlpw_pkg::CW-1:0] goal_drive = '0;
  logic                           wdec [3] = '{0, 0, 0};
  logic [vlpw_pkg::CW:0]          wspan [3] = '{0, 0, 0};
  vlpw_pkg::axis_t                waxis = vlpw_pkg::AXIS_X;
  logic signed [vlpw_pkg::EW-1:0] werr [2] = '{0, 0};

  voxel_line_pick_walker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_start_z (in_start_z),
    .in_goal_x  (in_goal_x),
    .in_goal_y  (in_goal_y),
    .in_goal_z  (in_goal_z),
    .in_visible (in_visible),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_vox_x  (out_vox_x),
    .out_vox_y  (out_vox_y),
    .out_vox_z  (out_vox_z)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task nudge(input int ax);
    wpos[ax] = wdec[ax] ? wpos[ax] - 1'b1 : wpos[ax] + 1'b1;
  endtask

  task step_or_finish(output vox_word_t w);
    int d;
    int m0;
    int m1;
    d  = int'(waxis);
    m0 = (d == 0) ? 1 : 0;
    m1 = (d == 2) ? 1 : 2;
    if (wpos[d] == goal_drive) begin
      walk_on = 1'b0;
      w = '{vlpw_pkg::KIND_MISS, '0, '0, '0};
    end else begin
      nudge(d);
      if (!werr[0][vlpw_pkg::EW-1]) begin
        nudge(m0);
        werr[0] = werr[0] - vlpw_pkg::EW'(2 * int'(wspan[d]));
      end
      if (!werr[1][vlpw_pkg::EW-1]) begin
        nudge(m1);
        werr[1] = werr[1] - vlpw_pkg::EW'(2 * int'(wspan[d]));
      end
      werr[0] = werr[0] + vlpw_pkg::EW'(2 * int'(wspan[m0]));
      werr[1] = werr[1] + vlpw_pkg::EW'(2 * int'(wspan[m1]));
      walk_on = 1'b1;
      w = '{vlpw_pkg::KIND_PROBE, wpos[0], wpos[1], wpos[2]};
    end
  endtask

  task walk_step(input vlpw_pkg::op_t op,
                 input logic signed [vlpw_pkg::CW-1:0] sx, sy, sz, gx, gy, gz,
                 input logic vis, output vox_word_t w);
    int a [3];
    int b [3];
    int d;
    int m0;
    int m1;
    a = '{sx, sy, sz};
    b = '{gx, gy, gz};
    w = '{vlpw_pkg::KIND_IDLE, '0, '0, '0};
    if (op == vlpw_pkg::OP_START) begin
      for (int i = 0; i < 3; i++) begin
        wpos[i]  = vlpw_pkg::CW'(a[i]);
        wdec[i]  = a[i] > b[i];
        wspan[i] = (vlpw_pkg::CW+1)'((a[i] > b[i]) ? a[i] - b[i] : b[i] - a[i]);
      end
      if (wspan[0] >= wspan[1] && wspan[0] >= wspan[2]) waxis = vlpw_pkg::AXIS_X;
      else if (wspan[1] >= wspan[2]) waxis = vlpw_pkg::AXIS_Y;
      else waxis = vlpw_pkg::AXIS_Z;
      d  = int'(waxis);
      m0 = (d == 0) ? 1 : 0;
      m1 = (d == 2) ? 1 : 2;
      goal_drive = vlpw_pkg::CW'(b[d]);
      werr[0] = vlpw_pkg::EW'(2 * int'(wspan[m0]) - int'(wspan[d]));
      werr[1] = vlpw_pkg::EW'(2 * int'(wspan[m1]) - int'(wspan[d]));
      step_or_finish(w);
    end else if (walk_on) begin
      if (vis) begin
        walk_on = 1'b0;
        w = '{vlpw_pkg::KIND_HIT, wpos[0], wpos[1], wpos[2]};
      end else begin
        step_or_finish(w);
      end
    end
  endtask

  always @(posedge clk) begin : mon
    vox_word_t got;
    vox_word_t want;
    vox_word_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{vlpw_pkg::kind_t'(out_kind), out_vox_x, out_vox_y, out_vox_z};
        if (pending_vox.size() == 0) begin
          $error("unexpected result word: kind %0d", got.kind);
          n_bad++;
        end else begin
          want = pending_vox.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            n_bad++;
          end
          if (got.x !== want.x) begin
            $error("vox_x: expected %0d, got %0d", want.x, got.x);
            n_bad++;
          end
          if (got.y !== want.y) begin
            $error("vox_y: expected %0d, got %0d", want.y, got.y);
            n_bad++;
          end
          if (got.z !== want.z) begin
            $error("vox_z: expected %0d, got %0d", want.z, got.z);
            n_bad++;
          end
        end
      end
      if (in_valid && in_ready) begin
        walk_step(vlpw_pkg::op_t'(in_op), in_start_x, in_start_y, in_start_z,
                  in_goal_x, in_goal_y, in_goal_z, in_visible, pred);
        pending_vox.insert(pending_vox.size(), row_typed ? row_want : pred);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task send_word(input dir_row_t r);
    in_op      <= r.op;
    in_start_x <= r.sx;
    in_start_y <= r.sy;
    in_start_z <= r.sz;
    in_goal_x  <= r.gx;
    in_goal_y  <= r.gy;
    in_goal_z  <= r.gz;
    in_visible <= r.vis;
    row_typed  <= r.typed;
    row_want   <= r.want;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task idle_gap(input bit quiet);
    if (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  initial begin : rx_side
    int cyc;
    cyc = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 200 && cyc < 290) out_ready <= 1'b0;
      else if (cyc >= 500 && cyc < 700) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 29);
    end
  end

  initial begin : stim
    dir_row_t dir_tab [20];
    dir_row_t r;
    int       sel;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_op      <= vlpw_pkg::OP_START;
    in_start_x <= '0;
    in_start_y <= '0;
    in_start_z <= '0;
    in_goal_x  <= '0;
    in_goal_y  <= '0;
    in_goal_z  <= '0;
    in_visible <= 1'b0;
    row_typed  <= 1'b0;
    row_want   <= '0;
    dir_tab = '{
      '{vlpw_pkg::OP_REPLY, 32767, -1, -32768, -1, 32767, 21845, 1, 1,
        '{vlpw_pkg::KIND_IDLE, 0, 0, 0}},
      '{vlpw_pkg::OP_START, 5, 5, 5, 5, 5, 5, 1, 1,
        '{vlpw_pkg::KIND_MISS, 0, 0, 0}},
      '{vlpw_pkg::OP_START, 0, 0, 0, 3, 1, 0, 0, 1,
        '{vlpw_pkg::KIND_PROBE, 1, 0, 0}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 1,
        '{vlpw_pkg::KIND_MISS, 0, 0, 0}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 1,
        '{vlpw_pkg::KIND_IDLE, 0, 0, 0}},
      '{vlpw_pkg::OP_START, 0, 0, 0, -2, 2, 2, 0, 1,
        '{vlpw_pkg::KIND_PROBE, -1, 1, 1}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 1, 1,
        '{vlpw_pkg::KIND_HIT, -1, 1, 1}},
      '{vlpw_pkg::OP_START, 0, 0, 0, 1, -4, 4, 0, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_REPLY, -7, 123, -32768, 32767, -1, 9, 0, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 1, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_START, 10, 10, 10, 10, 10, -5, 0, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_START, -32768, -32768, -32768, 32767, 32767, 32767, 0, 1,
        '{vlpw_pkg::KIND_PROBE, -32767, -32767, -32767}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_START, 32767, -32768, 0, -32768, 32767, -1, 0, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 1, 0,
        '{vlpw_pkg::KIND_PROBE, 0, 0, 0}},
      '{vlpw_pkg::OP_START, 100, -100, 7, 101, -100, 7, 1, 1,
        '{vlpw_pkg::KIND_PROBE, 101, -100, 7}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 0, 1,
        '{vlpw_pkg::KIND_MISS, 0, 0, 0}},
      '{vlpw_pkg::OP_REPLY, 0, 0, 0, 0, 0, 0, 1, 1,
        '{vlpw_pkg::KIND_IDLE, 0, 0, 0}}
    };
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      idle_gap(1'b0);
      send_word(dir_tab[i]);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 150) begin
        in_valid <= 1'b0;
        while (pending_vox.size() != 0) @(negedge clk);
        @(negedge clk);
      end else begin
        idle_gap(n >= 250 && n < 350);
      end
      r = '0;
      r.sx  = vlpw_pkg::CW'($urandom);
      r.sy  = vlpw_pkg::CW'($urandom);
      r.sz  = vlpw_pkg::CW'($urandom);
      r.gx  = vlpw_pkg::CW'($urandom);
      r.gy  = vlpw_pkg::CW'($urandom);
      r.gz  = vlpw_pkg::CW'($urandom);
      r.vis = 1'($urandom_range(1));
      sel = $urandom_range(99);
      if (walk_on ? (sel < 6) : (sel >= 8)) begin
        r.op = vlpw_pkg::OP_START;
        sel = $urandom_range(99);
        if (sel < 85) begin
          r.gx = r.sx + vlpw_pkg::CW'(int'($urandom_range(10)) - 5);
          r.gy = r.sy + vlpw_pkg::CW'(int'($urandom_range(10)) - 5);
          r.gz = r.sz + vlpw_pkg::CW'(int'($urandom_range(10)) - 5);
        end else if (sel < 95) begin
          r.gx = r.sx + vlpw_pkg::CW'(int'($urandom_range(400)) - 200);
          r.gy = r.sy + vlpw_pkg::CW'(int'($urandom_range(400)) - 200);
          r.gz = r.sz + vlpw_pkg::CW'(int'($urandom_range(400)) - 200);
        end
      end else begin
        r.op  = vlpw_pkg::OP_REPLY;
        r.vis = ($urandom_range(99) < 12);
      end
      send_word(r);
    end

    in_valid <= 1'b0;
    while (pending_vox.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (n_bad == 0) begin
      $display("PASS voxel_line_pick_walker");
    end else begin
      $display("FAIL voxel_line_pick_walker");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL voxel_line_pick_walker");
    $finish;
  end

endmodule
